// ----- design/imd_pkg.sv -----
// ----------------------------------------------------------------------------
// imd_pkg: shared types and codes for the integer multiply/divide unit
// Operation codes, the control word that travels down the pipeline, fixed
// port widths.
// ----------------------------------------------------------------------------
package imd_pkg;

  localparam int OP_W   = 64;  // operand and result field width on the ports
  localparam int FUNC_W = 4;
  localparam int DEST_W = 5;

  localparam logic [FUNC_W-1:0] FN_MUL    = 4'd0;
  localparam logic [FUNC_W-1:0] FN_MULH   = 4'd1;
  localparam logic [FUNC_W-1:0] FN_MULHSU = 4'd2;
  localparam logic [FUNC_W-1:0] FN_MULHU  = 4'd3;
  localparam logic [FUNC_W-1:0] FN_DIV    = 4'd4;
  localparam logic [FUNC_W-1:0] FN_DIVU   = 4'd5;
  localparam logic [FUNC_W-1:0] FN_REM    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_REMU   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_MULW   = 4'd8;
  localparam logic [FUNC_W-1:0] FN_DIVW   = 4'd9;
  localparam logic [FUNC_W-1:0] FN_DIVUW  = 4'd10;
  localparam logic [FUNC_W-1:0] FN_REMW   = 4'd11;
  localparam logic [FUNC_W-1:0] FN_REMUW  = 4'd12;

  typedef struct packed {
    logic              valid;
    logic              is_div;    // divide or remainder
    logic              want_rem;
    logic              mul_hi;    // upper half of product
    logic              word;      // 32-bit form, sign-extend result
    logic              neg;       // negate product / quotient / remainder
    logic              illegal;
    logic [DEST_W-1:0] dest;
  } ctrl_t;

endpackage

// ----- design/integer_mul_div_unit.sv -----
// ----------------------------------------------------------------------------
// integer_mul_div_unit: pipelined integer multiply/divide unit
// Takes an operation, two operands and a destination index per word and
// returns one result word per input word, in order.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser carries the operation code; tdata carries, from
// bit 0 up, operand_a, operand_b, dest_index. Output stream m_*: tdata
// carries product_or_quotient then dest_out; tuser carries illegal_op.
// Every word, multiply or divide, runs the same pipeline: decode, three
// multiplier stages, XLEN restoring-divider stages (one quotient bit each)
// and the output register. One word per cycle is accepted and delivered
// when the receiver keeps up. A stall on m_tready freezes the whole
// pipeline and drops s_tready in the same cycle; nothing is lost or
// repeated. Synchronous reset empties all stages at once. Unused codes,
// and word forms at XLEN 32, return zero with illegal_op set.
// ----------------------------------------------------------------------------
module integer_mul_div_unit import imd_pkg::*; #(
  parameter int XLEN = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [135:0] s_tdata,   // operand_a[63:0], operand_b[127:64], dest_index[132:128]
  input  logic [3:0]   s_tuser,   // func[3:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata,   // product_or_quotient[63:0], dest_out[68:64]
  output logic         m_tuser    // illegal_op[0]
);

  logic            en;
  ctrl_t           pc;
  logic [XLEN-1:0] ma, mb;
  ctrl_t           dc [XLEN+1];
  logic [XLEN-1:0] dr [XLEN+1];
  logic [XLEN-1:0] dq [XLEN+1];
  logic [XLEN-1:0] dd [XLEN+1];
  logic [OP_W-1:0]   product;
  logic [DEST_W-1:0] dest_out;
  logic              illegal_op;

  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  imd_prep #(.XLEN(XLEN)) u_prep (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .func       (s_tuser),
    .operand_a  (s_tdata[63:0]),
    .operand_b  (s_tdata[127:64]),
    .dest_index (s_tdata[132:128]),
    .ctrl       (pc),
    .ma         (ma),
    .mb         (mb)
  );

  imd_mul #(.XLEN(XLEN)) u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctrl_in  (pc),
    .ma       (ma),
    .mb       (mb),
    .ctrl_out (dc[0]),
    .r_out    (dr[0]),
    .q_out    (dq[0]),
    .d_out    (dd[0])
  );

  for (genvar k = 0; k < XLEN; k++) begin : g_div
    imd_div_step #(.XLEN(XLEN)) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctrl_in  (dc[k]),
      .r_in     (dr[k]),
      .q_in     (dq[k]),
      .d_in     (dd[k]),
      .ctrl_out (dc[k+1]),
      .r_out    (dr[k+1]),
      .q_out    (dq[k+1]),
      .d_out    (dd[k+1])
    );
  end

  imd_result #(.XLEN(XLEN)) u_result (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctrl       (dc[XLEN]),
    .r_in       (dr[XLEN]),
    .q_in       (dq[XLEN]),
    .out_valid  (m_tvalid),
    .product    (product),
    .dest_out   (dest_out),
    .illegal_op (illegal_op)
  );

  assign m_tdata = {3'b000, dest_out, product};
  assign m_tuser = illegal_op;

  // illegal operations always return zero
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[63:0] == '0))
    else $error("illegal op with nonzero result");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("valid output right after reset");

  // results never carry bits above XLEN
  a_result_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[63:0] >> XLEN) == '0))
    else $error("result wider than XLEN");

endmodule

// ----- design/imd_prep.sv -----
// ----------------------------------------------------------------------------
// imd_prep: decode and operand preparation stage
// Decodes the operation, extends word operands, takes magnitudes and
// registers the control word.
// ----------------------------------------------------------------------------
module imd_prep import imd_pkg::*; #(
  parameter int XLEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [FUNC_W-1:0] func,
  input  logic [OP_W-1:0]   operand_a,
  input  logic [OP_W-1:0]   operand_b,
  input  logic [DEST_W-1:0] dest_index,
  output ctrl_t             ctrl,
  output logic [XLEN-1:0]   ma,
  output logic [XLEN-1:0]   mb
);

  localparam bit WORD_OK = (XLEN > 32);

  ctrl_t           c;
  logic            word, sgn_a, sgn_b, ext_s;
  logic [XLEN-1:0] a_ext, b_ext, ma_next, mb_next;
  logic            na, nb, dz;

  always_comb begin
    c      = '0;
    word   = 1'b0;
    sgn_a  = 1'b0;
    sgn_b  = 1'b0;
    ext_s  = 1'b0;
    case (func)
      FN_MUL:    ;
      FN_MULH:   begin c.mul_hi = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1; end
      FN_MULHSU: begin c.mul_hi = 1'b1; sgn_a = 1'b1; end
      FN_MULHU:  c.mul_hi = 1'b1;
      FN_DIV:    begin c.is_div = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1; end
      FN_DIVU:   c.is_div = 1'b1;
      FN_REM:    begin c.is_div = 1'b1; c.want_rem = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1; end
      FN_REMU:   begin c.is_div = 1'b1; c.want_rem = 1'b1; end
      FN_MULW:   word = 1'b1;
      FN_DIVW:   begin
        word = 1'b1; c.is_div = 1'b1; sgn_a = 1'b1; sgn_b = 1'b1; ext_s = 1'b1;
      end
      FN_DIVUW:  begin word = 1'b1; c.is_div = 1'b1; end
      FN_REMW:   begin
        word = 1'b1; c.is_div = 1'b1; c.want_rem = 1'b1;
        sgn_a = 1'b1; sgn_b = 1'b1; ext_s = 1'b1;
      end
      FN_REMUW:  begin word = 1'b1; c.is_div = 1'b1; c.want_rem = 1'b1; end
      default:   c.illegal = 1'b1;
    endcase
    if (word && !WORD_OK) c.illegal = 1'b1;
    c.word  = word;
    c.valid = in_valid;
    c.dest  = dest_index;
    c.neg   = c.is_div ? (c.want_rem ? na : ((na ^ nb) & ~dz)) : (na ^ nb);
  end

  // word forms run as full-width ops on extended operands
  always_comb begin
    for (int i = 0; i < XLEN; i++) begin
      a_ext[i] = (word && i >= 32) ? (ext_s & operand_a[31]) : operand_a[i];
      b_ext[i] = (word && i >= 32) ? (ext_s & operand_b[31]) : operand_b[i];
    end
  end

  assign na      = sgn_a & a_ext[XLEN-1];
  assign nb      = sgn_b & b_ext[XLEN-1];
  assign dz      = (b_ext == '0);
  assign ma_next = na ? ('0 - a_ext) : a_ext;
  assign mb_next = nb ? ('0 - b_ext) : b_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma <= ma_next;
      mb <= mb_next;
    end
  end

endmodule

// ----- design/imd_mul.sv -----
// ----------------------------------------------------------------------------
// imd_mul: three-stage magnitude multiplier
// Half-width partial products, then their sum, then sign fix. Divide words
// pass through and leave loaded for the divider array.
// ----------------------------------------------------------------------------
module imd_mul import imd_pkg::*; #(
  parameter int XLEN = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ctrl_t           ctrl_in,
  input  logic [XLEN-1:0] ma,
  input  logic [XLEN-1:0] mb,
  output ctrl_t           ctrl_out,
  output logic [XLEN-1:0] r_out,
  output logic [XLEN-1:0] q_out,
  output logic [XLEN-1:0] d_out
);

  localparam int H  = (XLEN + 1) / 2;
  localparam int W2 = 2 * H;

  logic [W2-1:0]   a_p, b_p;
  ctrl_t           c1, c2;
  logic [XLEN-1:0] ma1, mb1, ma2, mb2;
  logic [W2-1:0]   pp00, pp01, pp10, pp11;
  logic [2*W2-1:0] sum_next, prod;
  logic [2*XLEN-1:0] p_fix;

  assign a_p = W2'(ma);
  assign b_p = W2'(mb);

  assign sum_next = {pp11, pp00}
                  + {{H{1'b0}}, pp01, {H{1'b0}}}
                  + {{H{1'b0}}, pp10, {H{1'b0}}};

  always_comb begin
    p_fix = prod[2*XLEN-1:0];
    if (!c2.is_div && c2.neg) p_fix = '0 - p_fix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1       <= '0;
      c2       <= '0;
      ctrl_out <= '0;
    end else if (en) begin
      c1       <= ctrl_in;
      c2       <= c1;
      ctrl_out <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= a_p[H-1:0] * b_p[H-1:0];
      pp01 <= a_p[H-1:0] * b_p[W2-1:H];
      pp10 <= a_p[W2-1:H] * b_p[H-1:0];
      pp11 <= a_p[W2-1:H] * b_p[W2-1:H];
      ma1  <= ma;
      mb1  <= mb;
      prod <= sum_next;
      ma2  <= ma1;
      mb2  <= mb1;
      d_out <= mb2;
      if (c2.is_div) begin
        r_out <= '0;
        q_out <= ma2;
      end else begin
        r_out <= p_fix[2*XLEN-1:XLEN];
        q_out <= p_fix[XLEN-1:0];
      end
    end
  end

endmodule

// ----- design/imd_div_step.sv -----
// ----------------------------------------------------------------------------
// imd_div_step: one restoring-division stage
// Shifts one dividend bit into the partial remainder and settles one
// quotient bit. Product words are held unchanged.
// ----------------------------------------------------------------------------
module imd_div_step import imd_pkg::*; #(
  parameter int XLEN = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ctrl_t           ctrl_in,
  input  logic [XLEN-1:0] r_in,
  input  logic [XLEN-1:0] q_in,
  input  logic [XLEN-1:0] d_in,
  output ctrl_t           ctrl_out,
  output logic [XLEN-1:0] r_out,
  output logic [XLEN-1:0] q_out,
  output logic [XLEN-1:0] d_out
);

  logic [XLEN:0] rr, diff;
  logic          ge;

  assign rr   = {r_in, q_in[XLEN-1]};
  assign diff = rr - {1'b0, d_in};
  assign ge   = ~diff[XLEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else if (en) begin
      ctrl_out <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_in;
      if (ctrl_in.is_div) begin
        r_out <= ge ? diff[XLEN-1:0] : rr[XLEN-1:0];
        q_out <= {q_in[XLEN-2:0], ge};
      end else begin
        r_out <= r_in;
        q_out <= q_in;
      end
    end
  end

endmodule

// ----- design/imd_result.sv -----
// ----------------------------------------------------------------------------
// imd_result: result select and output register
// Picks the half or quotient/remainder, applies the divide sign, extends
// word results and holds the output word for the receiver.
// ----------------------------------------------------------------------------
module imd_result import imd_pkg::*; #(
  parameter int XLEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ctrl_t             ctrl,
  input  logic [XLEN-1:0]   r_in,
  input  logic [XLEN-1:0]   q_in,
  output logic              out_valid,
  output logic [OP_W-1:0]   product,
  output logic [DEST_W-1:0] dest_out,
  output logic              illegal_op
);

  logic [XLEN-1:0] sel, signed_sel, res;

  always_comb begin
    if (ctrl.is_div) sel = ctrl.want_rem ? r_in : q_in;
    else             sel = ctrl.mul_hi ? r_in : q_in;
    signed_sel = (ctrl.is_div && ctrl.neg) ? ('0 - sel) : sel;
    for (int i = 0; i < XLEN; i++) begin
      res[i] = (ctrl.word && i >= 32) ? signed_sel[31] : signed_sel[i];
    end
    if (ctrl.illegal) res = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product    <= OP_W'(res);
      dest_out   <= ctrl.dest;
      illegal_op <= ctrl.illegal;
    end
  end

endmodule

// ----- test/imd_checker.sv -----
// ----------------------------------------------------------------------------
// imd_checker: result predictor and scoreboard for integer_mul_div_unit
// Watches both streams at the rising edge, computes the expected result of
// every accepted input word and compares each output word in order.
// ----------------------------------------------------------------------------
module imd_checker import imd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic [3:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,
  input  logic         m_tuser,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [63:0]       value;
    logic [DEST_W-1:0] dest;
    logic              illegal;
  } result_t;

  result_t expected_q[$];

  // kind uses the full-width codes FN_MUL..FN_REMU; w is 32 or 64
  function automatic logic [63:0] muldiv_value(logic [3:0] kind, logic [63:0] a,
                                               logic [63:0] b, int w);
    logic [63:0]  m, ua, ub, sa, sb, q, r;
    logic [127:0] p;
    logic signed [127:0] ps;
    m  = (w == 64) ? '1 : 64'hffff_ffff;
    ua = a & m;
    ub = b & m;
    sa = (w == 64) ? a : {{32{a[31]}}, a[31:0]};
    sb = (w == 64) ? b : {{32{b[31]}}, b[31:0]};
    case (kind)
      FN_MUL: return (ua * ub) & m;
      FN_MULH: begin
        ps = $signed({{64{sa[63]}}, sa}) * $signed({{64{sb[63]}}, sb});
        p = ps;
        return (p >> w) & m;
      end
      FN_MULHSU: begin
        ps = $signed({{64{sa[63]}}, sa}) * $signed({64'd0, ub});
        p = ps;
        return (p >> w) & m;
      end
      FN_MULHU: begin
        p = {64'd0, ua} * {64'd0, ub};
        return (p >> w) & m;
      end
      FN_DIVU: return (ub == 0) ? m : ua / ub;
      FN_REMU: return (ub == 0) ? ua : ua % ub;
      default: begin
        if (ub == 0) begin
          q = m;
          r = ua;
        end else if (ua == (64'd1 << (w - 1)) && ub == m) begin
          q = ua;
          r = 0;
        end else begin
          q = (sa[63] ? -sa : sa) / (sb[63] ? -sb : sb);
          r = (sa[63] ? -sa : sa) % (sb[63] ? -sb : sb);
          if (sa[63] != sb[63]) q = -q;
          if (sa[63]) r = -r;
        end
        return ((kind == FN_REM) ? r : q) & m;
      end
    endcase
  endfunction

  function automatic result_t predict_result(logic [3:0] fn, logic [63:0] a,
                                             logic [63:0] b, logic [4:0] d);
    result_t res;
    logic [63:0] v;
    res.dest = d;
    res.illegal = 1'b0;
    res.value = '0;
    if (fn <= FN_REMU) begin
      res.value = muldiv_value(fn, a, b, 64);
    end else if (fn <= FN_REMUW) begin
      case (fn)
        FN_MULW:  v = muldiv_value(FN_MUL, a, b, 32);
        FN_DIVW:  v = muldiv_value(FN_DIV, a, b, 32);
        FN_DIVUW: v = muldiv_value(FN_DIVU, a, b, 32);
        FN_REMW:  v = muldiv_value(FN_REM, a, b, 32);
        default:  v = muldiv_value(FN_REMU, a, b, 32);
      endcase
      res.value = {{32{v[31]}}, v[31:0]};
    end else begin
      res.illegal = 1'b1;
    end
    return res;
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_q.push_back(predict_result(s_tuser, s_tdata[63:0], s_tdata[127:64],
                                            s_tdata[132:128]));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $error("output word with nothing expected");
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (m_tdata[63:0] !== want.value) begin
            $error("product_or_quotient expected %h actual %h", want.value, m_tdata[63:0]);
            fail_count++;
          end
          if (m_tdata[68:64] !== want.dest) begin
            $error("dest_out expected %0d actual %0d", want.dest, m_tdata[68:64]);
            fail_count++;
          end
          if (m_tuser !== want.illegal) begin
            $error("illegal_op expected %0b actual %0b", want.illegal, m_tuser);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// ----- test/tb_integer_mul_div_unit.sv -----
// ----------------------------------------------------------------------------
// tb_integer_mul_div_unit: stream testbench for integer_mul_div_unit
// Directed corner operands for every operation, then random words with
// random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_integer_mul_div_unit;
  import imd_pkg::*;

  localparam int RANDOM_WORDS = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [135:0] s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         m_tuser;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  bit           calm = 1'b0;    // no idling while set
  bit           hold_off = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  integer_mul_div_unit dut (.*);

  imd_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random idling, plus one long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 34);
  end

  function automatic logic [63:0] corner_value();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h8000_0000_0000_0000;
      4: return 64'h7fff_ffff_ffff_ffff;
      5: return 64'h0000_0000_8000_0000;
      6: return 64'hffff_ffff_ffff_ffff ^ 64'h0000_0000_7fff_ffff;
      7: return 64'h0000_0000_ffff_ffff;
      8: return {32'd0, $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_word(logic [3:0] fn, logic [63:0] a, logic [63:0] b, logic [4:0] d);
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {3'd0, d, b, a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 34) begin
      s_tvalid <= 1'b0;
      repeat (1 + $urandom_range(2)) @(negedge clk);
    end
  endtask

  initial begin
    logic [63:0] a, b;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // every code, with divide-by-zero and overflow cases
    for (int f = 0; f < 16; f++)
      send_word(f[3:0], 64'h8000_0000_0000_0000, '1, f[4:0]);
    send_word(FN_DIV, 64'h1234, 64'd0, 5'd31);
    send_word(FN_REMU, '1, 64'd0, 5'd0);
    send_word(FN_DIVW, 64'h0000_0000_8000_0000, 64'hffff_ffff, 5'd3);
    send_word(FN_REMW, 64'hdead_0000_8000_0000, 64'd0, 5'd4);
    send_word(FN_MULHSU, '1, '1, 5'd5);
    send_word(FN_MULHU, '1, '1, 5'd6);
    send_word(FN_REM, 64'hffff_ffff_ffff_fff9, 64'd2, 5'd7);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 100) calm = 1'b1;
      if (i == 160) calm = 1'b0;
      if (i == 220) begin
        hold_off = 1'b1;
        fork
          begin
            repeat (200) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      a = ($urandom_range(1)) ? corner_value() : {$urandom(), $urandom()};
      b = ($urandom_range(1)) ? corner_value() : {$urandom(), $urandom()};
      if ($urandom_range(15) == 0) b = 64'd0;
      send_word(4'($urandom_range(15)), a, b, 5'($urandom_range(31)));
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
